>>> hdl/ils_pkg.sv
// Shared constants for the intercept lead solver.
`default_nettype none

package ils_pkg;

   // Fixed field widths of the velocity and speed inputs
   localparam int VEL_WIDTH = 20;
   localparam int SPD_WIDTH = 19;

   // Integer bits of the internal time-to-intercept
   localparam int TIME_INT_BITS = 16;

endpackage

`default_nettype wire

>>> hdl/intercept_lead_solver_unit.sv
// Pipelined intercept lead solver: quadratic time-to-intercept, aim point and range.
`default_nettype none

// The unit takes one item in every clock cycle and never raises busy. Each item gives exactly
// one result, marked by rsp_strobe for a single cycle. SQW, the width of the discriminant root,
// is half the padded width of the discriminant (48 by default), and TW, the width of each time
// quotient, is TIME_INT_BITS + TIME_FRAC_BITS, or 16 + TIME_FRAC_BITS. The latency is mostly set
// by the two one-bit-per-stage square roots (discriminant and range) and by the two radix-2
// divider lanes that form the candidate times. Results cannot be held off: the receiver must
// take every strobed item. With no lock, zero speed or no forward root, the result has
// rsp_solution_valid low and all other fields zero.
module intercept_lead_solver_unit
   import ils_pkg::*;
#(
   parameter int POS_WIDTH      = 24,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_target_present,
   input  logic signed [POS_WIDTH-1:0] req_target_x,
   input  logic signed [POS_WIDTH-1:0] req_target_y,
   input  logic signed [POS_WIDTH-1:0] req_target_z,
   input  logic signed [VEL_WIDTH-1:0] req_target_vx,
   input  logic signed [VEL_WIDTH-1:0] req_target_vy,
   input  logic signed [VEL_WIDTH-1:0] req_target_vz,
   input  logic signed [POS_WIDTH-1:0] req_shooter_x,
   input  logic signed [POS_WIDTH-1:0] req_shooter_y,
   input  logic signed [POS_WIDTH-1:0] req_shooter_z,
   input  logic [SPD_WIDTH-1:0]        req_projectile_speed,
   output logic                        rsp_strobe,
   output logic                        rsp_solution_valid,
   output logic signed [POS_WIDTH-1:0] rsp_aim_x,
   output logic signed [POS_WIDTH-1:0] rsp_aim_y,
   output logic signed [POS_WIDTH-1:0] rsp_aim_z,
   output logic [POS_WIDTH:0]          rsp_aim_distance
);

   localparam int PW   = POS_WIDTH;
   localparam int TF   = TIME_FRAC_BITS;
   localparam int VW   = VEL_WIDTH;
   localparam int SW   = SPD_WIDTH;
   localparam int TW   = TIME_INT_BITS + TIME_FRAC_BITS;
   localparam int RW   = PW + 1;
   localparam int RVW  = RW + VW + 2;
   localparam int RRW  = 2 * RW;
   localparam int VVW  = 2 * VW;
   localparam int SSW  = 2 * SW;
   localparam int AW   = ((VVW > SSW) ? VVW : SSW) + 1;
   localparam int HHW  = 2 * RVW;
   localparam int ACW  = AW + RRW;
   localparam int DW0  = ((HHW > ACW) ? HHW : ACW) + 1;
   localparam int DW   = DW0 + (DW0 % 2);
   localparam int SQW  = DW / 2;
   localparam int RMW  = SQW + 3;
   localparam int NW   = ((RVW > SQW + 1) ? RVW : SQW + 1) + 1;
   localparam int NMW  = (NW > RRW) ? NW : RRW;
   localparam int NDW  = NMW + TF;
   localparam int DVW  = (AW > RVW + 1) ? AW : RVW + 1;
   localparam int CW   = NDW + DVW + TW;
   localparam int HLO  = RVW / 2;
   localparam int HHI  = RVW - HLO;
   localparam int ALO  = AW / 2;
   localparam int AHI  = AW - ALO;
   localparam int RLO  = RRW / 2;
   localparam int RHI  = RRW - RLO;
   localparam int PRW  = VW + TW + 1;
   localparam int SUMW = ((PW > PRW - TF) ? PW : PRW - TF) + 1;
   localparam int DSW  = 2 * PW + 2;
   localparam int DQW  = PW + 1;
   localparam int DRMW = DQW + 3;
   localparam int LAT  = 17 + SQW + TW + DQW;

   typedef struct packed {
      logic [2:0][PW-1:0] tp;
      logic [2:0][VW-1:0] vel;
      logic [2:0][PW-1:0] sh;
   } ctx_type;

   typedef struct packed {
      ctx_type          ctx;
      logic [RVW-1:0]   rv;
      logic [RRW-1:0]   rr;
      logic [RVW-1:0]   mag_rv;
      logic [AW-1:0]    mag_a;
      logic             a_zero;
      logic             a_neg;
      logic             lin_ok;
      logic             quad_ok;
      logic             disc_ok;
   } sq_type;

   typedef struct packed {
      logic [DVW-1:0] d;
      logic [DVW-1:0] rem;
      logic [TW-1:0]  lo;
      logic [TW-1:0]  q;
      logic           sat;
      logic           en;
   } div_type;

   typedef struct packed {
      logic               sol;
      logic [2:0][PW-1:0] aim;
   } dc_type;

   // ---------------------------------------------------------------- front stages
   logic                  v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   ctx_type               ctx0_ff, ctx1_ff, ctx2_ff, ctx3_ff;
   logic                  pres0_ff;
   logic [SW-1:0]         spd0_ff, spd1_ff;
   logic                  ok1_ff, ok2_ff, ok3_ff;
   logic signed [RW-1:0]  r1_ff [3];
   logic signed [RVW-1:0] rv2_ff [3];
   logic [RRW-1:0]        rr2_ff [3];
   logic signed [VVW-1:0] vv2_ff [3];
   logic [SSW-1:0]        ss2_ff;
   logic signed [RVW-1:0] rv3_ff;
   logic [RRW-1:0]        rr3_ff;
   logic signed [AW-1:0]  a3_ff;
   sq_type                q4_ff, q5_ff, q6_ff, q7_ff;
   sq_type                q7_in;
   logic [2*HLO-1:0]      hh_ll5_ff;
   logic [HLO+HHI-1:0]    hh_lh5_ff;
   logic [2*HHI-1:0]      hh_hh5_ff;
   logic [ALO+RLO-1:0]    ac_ll5_ff;
   logic [ALO+RHI-1:0]    ac_lh5_ff;
   logic [AHI+RLO-1:0]    ac_hl5_ff;
   logic [AHI+RHI-1:0]    ac_hh5_ff;
   logic [HHW-1:0]        hh6_ff;
   logic [ACW-1:0]        ac6_ff;
   logic [DW-1:0]         disc7_ff;

   assign busy = 1'b0;

   // Advance the valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Capture the item, form r, the dot products and the quadratic coefficients
   always_ff @(posedge clock) begin
      ctx0_ff.tp  <= {req_target_z, req_target_y, req_target_x};
      ctx0_ff.vel <= {req_target_vz, req_target_vy, req_target_vx};
      ctx0_ff.sh  <= {req_shooter_z, req_shooter_y, req_shooter_x};
      pres0_ff    <= req_target_present;
      spd0_ff     <= req_projectile_speed;

      ctx1_ff <= ctx0_ff;
      spd1_ff <= spd0_ff;
      ok1_ff  <= pres0_ff && (spd0_ff != '0);
      for (int i = 0; i < 3; i++) begin
         r1_ff[i] <= RW'($signed(ctx0_ff.tp[i])) - RW'($signed(ctx0_ff.sh[i]));
      end

      ctx2_ff <= ctx1_ff;
      ok2_ff  <= ok1_ff;
      ss2_ff  <= SSW'(spd1_ff) * SSW'(spd1_ff);
      for (int i = 0; i < 3; i++) begin
         rv2_ff[i] <= RVW'(r1_ff[i]) * RVW'($signed(ctx1_ff.vel[i]));
         rr2_ff[i] <= RRW'(RRW'(r1_ff[i]) * RRW'(r1_ff[i]));
         vv2_ff[i] <= VVW'($signed(ctx1_ff.vel[i])) * VVW'($signed(ctx1_ff.vel[i]));
      end

      ctx3_ff <= ctx2_ff;
      ok3_ff  <= ok2_ff;
      rv3_ff  <= rv2_ff[0] + rv2_ff[1] + rv2_ff[2];
      rr3_ff  <= rr2_ff[0] + rr2_ff[1] + rr2_ff[2];
      a3_ff   <= AW'(vv2_ff[0]) + AW'(vv2_ff[1]) + AW'(vv2_ff[2]) - $signed(AW'(ss2_ff));
   end

   // Take magnitudes and classify the leading term
   always_ff @(posedge clock) begin
      q4_ff.ctx     <= ctx3_ff;
      q4_ff.rv      <= rv3_ff;
      q4_ff.rr      <= rr3_ff;
      q4_ff.mag_rv  <= rv3_ff[RVW-1] ? RVW'(-rv3_ff) : RVW'(rv3_ff);
      q4_ff.mag_a   <= a3_ff[AW-1] ? AW'(-a3_ff) : AW'(a3_ff);
      q4_ff.a_zero  <= (a3_ff == '0);
      q4_ff.a_neg   <= a3_ff[AW-1];
      q4_ff.lin_ok  <= ok3_ff && (a3_ff == '0) && rv3_ff[RVW-1] && (rr3_ff != '0);
      q4_ff.quad_ok <= ok3_ff && (a3_ff != '0);
      q4_ff.disc_ok <= 1'b0;
   end

   // Split H*H and |A|*C into partial products
   always_ff @(posedge clock) begin
      q5_ff     <= q4_ff;
      hh_ll5_ff <= (2*HLO)'(q4_ff.mag_rv[HLO-1:0]) * (2*HLO)'(q4_ff.mag_rv[HLO-1:0]);
      hh_lh5_ff <= (HLO+HHI)'(q4_ff.mag_rv[HLO-1:0]) * (HLO+HHI)'(q4_ff.mag_rv[RVW-1:HLO]);
      hh_hh5_ff <= (2*HHI)'(q4_ff.mag_rv[RVW-1:HLO]) * (2*HHI)'(q4_ff.mag_rv[RVW-1:HLO]);
      ac_ll5_ff <= (ALO+RLO)'(q4_ff.mag_a[ALO-1:0]) * (ALO+RLO)'(q4_ff.rr[RLO-1:0]);
      ac_lh5_ff <= (ALO+RHI)'(q4_ff.mag_a[ALO-1:0]) * (ALO+RHI)'(q4_ff.rr[RRW-1:RLO]);
      ac_hl5_ff <= (AHI+RLO)'(q4_ff.mag_a[AW-1:ALO]) * (AHI+RLO)'(q4_ff.rr[RLO-1:0]);
      ac_hh5_ff <= (AHI+RHI)'(q4_ff.mag_a[AW-1:ALO]) * (AHI+RHI)'(q4_ff.rr[RRW-1:RLO]);
   end

   // Sum the partial products
   always_ff @(posedge clock) begin
      q6_ff  <= q5_ff;
      hh6_ff <= (HHW'(hh_hh5_ff) << (2*HLO)) + (HHW'(hh_lh5_ff) << (HLO+1))
              + HHW'(hh_ll5_ff);
      ac6_ff <= (ACW'(ac_hh5_ff) << (ALO+RLO)) + (ACW'(ac_hl5_ff) << ALO)
              + (ACW'(ac_lh5_ff) << RLO) + ACW'(ac_ll5_ff);
   end

   // Flag a usable discriminant
   always_comb begin
      q7_in         = q6_ff;
      q7_in.disc_ok = q6_ff.quad_ok && (q6_ff.a_neg || (hh6_ff >= HHW'(ac6_ff)));
   end

   // Form the discriminant H*H - A*C and drop negative ones
   always_ff @(posedge clock) begin
      q7_ff         <= q7_in;
      disc7_ff      <= q6_ff.a_neg ? (DW'(hh6_ff) + DW'(ac6_ff)) : (DW'(hh6_ff) - DW'(ac6_ff));
   end

   // ---------------------------------------------------------------- discriminant root
   logic               sqv_ff   [SQW];
   sq_type             sqq_ff   [SQW];
   logic [DW-1:0]      sqrad_ff [SQW];
   logic [SQW-1:0]     sqrt_ff  [SQW];
   logic [RMW-1:0]     sqrem_ff [SQW];
   logic [DW-1:0]      sqrad_src [SQW];
   logic [SQW-1:0]     sqrt_src  [SQW];
   logic [RMW-1:0]     sqrem_src [SQW];
   logic [SQW-1:0]     sqrt_in   [SQW];
   logic [RMW-1:0]     sqrem_in  [SQW];

   // Select each stage's source
   always_comb begin
      sqrad_src[0] = disc7_ff;
      sqrt_src[0]  = '0;
      sqrem_src[0] = '0;
      for (int j = 1; j < SQW; j++) begin
         sqrad_src[j] = sqrad_ff[j-1];
         sqrt_src[j]  = sqrt_ff[j-1];
         sqrem_src[j] = sqrem_ff[j-1];
      end
   end

   // Resolve one root bit per stage
   always_comb begin
      logic [RMW-1:0] rem_sh;
      logic [RMW-1:0] trial;
      for (int j = 0; j < SQW; j++) begin
         rem_sh = {sqrem_src[j][RMW-3:0], sqrad_src[j][DW-1-2*j -: 2]};
         trial  = RMW'({sqrt_src[j], 2'b01});
         if (rem_sh >= trial) begin
            sqrem_in[j] = rem_sh - trial;
            sqrt_in[j]  = {sqrt_src[j][SQW-2:0], 1'b1};
         end else begin
            sqrem_in[j] = rem_sh;
            sqrt_in[j]  = {sqrt_src[j][SQW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQW; j++) begin
            sqv_ff[j] <= 1'b0;
         end
      end else begin
         sqv_ff[0] <= v7_ff;
         for (int j = 1; j < SQW; j++) begin
            sqv_ff[j] <= sqv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sqq_ff[0] <= q7_ff;
      for (int j = 1; j < SQW; j++) begin
         sqq_ff[j] <= sqq_ff[j-1];
      end
      for (int j = 0; j < SQW; j++) begin
         sqrad_ff[j] <= sqrad_src[j];
         sqrt_ff[j]  <= sqrt_in[j];
         sqrem_ff[j] <= sqrem_in[j];
      end
   end

   // ---------------------------------------------------------------- divider setup
   logic            nd_v_ff;
   ctx_type         nd_ctx_ff;
   logic [NDW-1:0]  nd_dvd_ff [2];
   logic [DVW-1:0]  nd_dsr_ff [2];
   logic            nd_en_ff  [2];
   logic [NDW-1:0]  nd_dvd_in [2];
   logic [DVW-1:0]  nd_dsr_in [2];
   logic            nd_en_in  [2];

   // Form both quadratic numerators, or the linear case on lane 0
   always_comb begin
      sq_type              qs;
      logic signed [NW-1:0] rvx;
      logic signed [NW-1:0] rtx;
      logic signed [NW-1:0] num_p;
      logic signed [NW-1:0] num_m;
      logic [NMW-1:0]       mag_p;
      logic [NMW-1:0]       mag_m;
      logic                 qual_p;
      logic                 qual_m;
      qs     = sqq_ff[SQW-1];
      rvx    = NW'($signed(qs.rv));
      rtx    = $signed(NW'(sqrt_ff[SQW-1]));
      num_p  = rtx - rvx;
      num_m  = -rtx - rvx;
      mag_p  = num_p[NW-1] ? NMW'(-num_p) : NMW'(num_p);
      mag_m  = num_m[NW-1] ? NMW'(-num_m) : NMW'(num_m);
      qual_p = (num_p != '0) && (num_p[NW-1] == qs.a_neg);
      qual_m = (num_m != '0) && (num_m[NW-1] == qs.a_neg);
      if (qs.a_zero) begin
         nd_dvd_in[0] = NDW'(qs.rr) << TF;
         nd_dsr_in[0] = DVW'({qs.mag_rv, 1'b0});
         nd_en_in[0]  = qs.lin_ok;
      end else begin
         nd_dvd_in[0] = NDW'(mag_p) << TF;
         nd_dsr_in[0] = DVW'(qs.mag_a);
         nd_en_in[0]  = qs.disc_ok && qual_p;
      end
      nd_dvd_in[1] = NDW'(mag_m) << TF;
      nd_dsr_in[1] = DVW'(qs.mag_a);
      nd_en_in[1]  = !qs.a_zero && qs.disc_ok && qual_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_v_ff <= 1'b0;
      end else begin
         nd_v_ff <= sqv_ff[SQW-1];
      end
   end

   always_ff @(posedge clock) begin
      nd_ctx_ff <= sqq_ff[SQW-1].ctx;
      for (int l = 0; l < 2; l++) begin
         nd_dvd_ff[l] <= nd_dvd_in[l];
         nd_dsr_ff[l] <= nd_dsr_in[l];
         nd_en_ff[l]  <= nd_en_in[l];
      end
   end

   // Flag quotient overflow and load the partial remainder
   logic                st_v_ff;
   ctx_type             st_ctx_ff;
   div_type [1:0]       st_lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff <= 1'b0;
      end else begin
         st_v_ff <= nd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [NDW+DVW-1:0] hi_part;
      st_ctx_ff <= nd_ctx_ff;
      for (int l = 0; l < 2; l++) begin
         hi_part               = (NDW+DVW)'(nd_dvd_ff[l]) >> TW;
         st_lane_ff[l].d      <= nd_dsr_ff[l];
         st_lane_ff[l].rem    <= hi_part[DVW-1:0];
         st_lane_ff[l].lo     <= nd_dvd_ff[l][TW-1:0];
         st_lane_ff[l].q      <= '0;
         st_lane_ff[l].sat    <= CW'(nd_dvd_ff[l]) >= (CW'(nd_dsr_ff[l]) << TW);
         st_lane_ff[l].en     <= nd_en_ff[l];
      end
   end

   // ---------------------------------------------------------------- radix-2 dividers
   logic            dv_v_ff    [TW];
   ctx_type         dv_ctx_ff  [TW];
   div_type [1:0]   dv_lane_ff [TW];
   div_type [1:0]   dv_src     [TW];
   div_type [1:0]   dv_in      [TW];

   always_comb begin
      dv_src[0] = st_lane_ff;
      for (int j = 1; j < TW; j++) begin
         dv_src[j] = dv_lane_ff[j-1];
      end
   end

   // Shift in one dividend bit and subtract where the divisor fits
   always_comb begin
      logic [DVW:0] r2;
      for (int j = 0; j < TW; j++) begin
         for (int l = 0; l < 2; l++) begin
            dv_in[j][l]    = dv_src[j][l];
            r2             = {dv_src[j][l].rem, dv_src[j][l].lo[TW-1]};
            dv_in[j][l].lo = {dv_src[j][l].lo[TW-2:0], 1'b0};
            if (r2 >= {1'b0, dv_src[j][l].d}) begin
               dv_in[j][l].rem = DVW'(r2 - {1'b0, dv_src[j][l].d});
               dv_in[j][l].q   = {dv_src[j][l].q[TW-2:0], 1'b1};
            end else begin
               dv_in[j][l].rem = r2[DVW-1:0];
               dv_in[j][l].q   = {dv_src[j][l].q[TW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TW; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else begin
         dv_v_ff[0] <= st_v_ff;
         for (int j = 1; j < TW; j++) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dv_ctx_ff[0] <= st_ctx_ff;
      for (int j = 1; j < TW; j++) begin
         dv_ctx_ff[j] <= dv_ctx_ff[j-1];
      end
      for (int j = 0; j < TW; j++) begin
         dv_lane_ff[j] <= dv_in[j];
      end
   end

   // ---------------------------------------------------------------- root selection
   logic            sel_v_ff;
   ctx_type         sel_ctx_ff;
   logic [TW-1:0]   best_ff;
   logic [TW-1:0]   best_in;

   // Keep the smallest qualifying time
   always_comb begin
      div_type [1:0] ln;
      logic [TW-1:0] t0;
      logic [TW-1:0] t1;
      logic          c0;
      logic          c1;
      ln = dv_lane_ff[TW-1];
      t0 = ln[0].sat ? {TW{1'b1}} : ln[0].q;
      t1 = ln[1].sat ? {TW{1'b1}} : ln[1].q;
      c0 = ln[0].en && (t0 != '0);
      c1 = ln[1].en && (t1 != '0);
      if (c0 && (!c1 || (t0 <= t1))) begin
         best_in = t0;
      end else if (c1) begin
         best_in = t1;
      end else begin
         best_in = '0;
      end
   end

   // ---------------------------------------------------------------- aim point
   logic                  a1_v_ff, a2_v_ff, a3_v_ff, a4_v_ff, a5_v_ff;
   ctx_type               a1_ctx_ff, a2_ctx_ff;
   logic                  a1_sol_ff;
   dc_type                a2_dc_ff, a3_dc_ff, a4_dc_ff, a5_dc_ff;
   logic signed [PRW-1:0] a1_prod_ff [3];
   logic signed [PW:0]    a3_d_ff    [3];
   logic [DSW-1:0]        a4_sq_ff   [3];
   logic [DSW-1:0]        a5_sum_ff;
   logic [2:0][PW-1:0]    aim_in;

   // Add the displacement and saturate each coordinate
   always_comb begin
      logic signed [PRW-1:0]  shv;
      logic signed [SUMW-1:0] sum;
      logic [SUMW-PW:0]       upper;
      for (int i = 0; i < 3; i++) begin
         shv   = a1_prod_ff[i] >>> TF;
         sum   = SUMW'($signed(a1_ctx_ff.tp[i])) + SUMW'(shv);
         upper = sum[SUMW-1:PW-1];
         if ((upper == '0) || (upper == '1)) begin
            aim_in[i] = sum[PW-1:0];
         end else if (sum[SUMW-1]) begin
            aim_in[i] = {1'b1, {(PW-1){1'b0}}};
         end else begin
            aim_in[i] = {1'b0, {(PW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_v_ff <= 1'b0;
         a1_v_ff  <= 1'b0;
         a2_v_ff  <= 1'b0;
         a3_v_ff  <= 1'b0;
         a4_v_ff  <= 1'b0;
         a5_v_ff  <= 1'b0;
      end else begin
         sel_v_ff <= dv_v_ff[TW-1];
         a1_v_ff  <= sel_v_ff;
         a2_v_ff  <= a1_v_ff;
         a3_v_ff  <= a2_v_ff;
         a4_v_ff  <= a3_v_ff;
         a5_v_ff  <= a4_v_ff;
      end
   end

   // Scale velocity by time, place the aim point, then square its offsets
   always_ff @(posedge clock) begin
      sel_ctx_ff <= dv_ctx_ff[TW-1];
      best_ff    <= best_in;

      a1_ctx_ff <= sel_ctx_ff;
      a1_sol_ff <= (best_ff != '0);
      for (int i = 0; i < 3; i++) begin
         a1_prod_ff[i] <= PRW'($signed(sel_ctx_ff.vel[i])) * $signed(PRW'(best_ff));
      end

      a2_ctx_ff    <= a1_ctx_ff;
      a2_dc_ff.sol <= a1_sol_ff;
      a2_dc_ff.aim <= aim_in;

      a3_dc_ff <= a2_dc_ff;
      for (int i = 0; i < 3; i++) begin
         a3_d_ff[i] <= (PW+1)'($signed(a2_dc_ff.aim[i])) - (PW+1)'($signed(a2_ctx_ff.sh[i]));
      end

      a4_dc_ff <= a3_dc_ff;
      for (int i = 0; i < 3; i++) begin
         a4_sq_ff[i] <= DSW'(DSW'(a3_d_ff[i]) * DSW'(a3_d_ff[i]));
      end

      a5_dc_ff  <= a4_dc_ff;
      a5_sum_ff <= a4_sq_ff[0] + a4_sq_ff[1] + a4_sq_ff[2];
   end

   // ---------------------------------------------------------------- range root
   logic            dqv_ff   [DQW];
   dc_type          dqc_ff   [DQW];
   logic [DSW-1:0]  dqrad_ff [DQW];
   logic [DQW-1:0]  dqrt_ff  [DQW];
   logic [DRMW-1:0] dqrem_ff [DQW];
   logic [DSW-1:0]  dqrad_src [DQW];
   logic [DQW-1:0]  dqrt_src  [DQW];
   logic [DRMW-1:0] dqrem_src [DQW];
   logic [DQW-1:0]  dqrt_in   [DQW];
   logic [DRMW-1:0] dqrem_in  [DQW];

   always_comb begin
      dqrad_src[0] = a5_sum_ff;
      dqrt_src[0]  = '0;
      dqrem_src[0] = '0;
      for (int j = 1; j < DQW; j++) begin
         dqrad_src[j] = dqrad_ff[j-1];
         dqrt_src[j]  = dqrt_ff[j-1];
         dqrem_src[j] = dqrem_ff[j-1];
      end
   end

   // Resolve one range bit per stage
   always_comb begin
      logic [DRMW-1:0] rem_sh;
      logic [DRMW-1:0] trial;
      for (int j = 0; j < DQW; j++) begin
         rem_sh = {dqrem_src[j][DRMW-3:0], dqrad_src[j][DSW-1-2*j -: 2]};
         trial  = DRMW'({dqrt_src[j], 2'b01});
         if (rem_sh >= trial) begin
            dqrem_in[j] = rem_sh - trial;
            dqrt_in[j]  = {dqrt_src[j][DQW-2:0], 1'b1};
         end else begin
            dqrem_in[j] = rem_sh;
            dqrt_in[j]  = {dqrt_src[j][DQW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DQW; j++) begin
            dqv_ff[j] <= 1'b0;
         end
      end else begin
         dqv_ff[0] <= a5_v_ff;
         for (int j = 1; j < DQW; j++) begin
            dqv_ff[j] <= dqv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dqc_ff[0] <= a5_dc_ff;
      for (int j = 1; j < DQW; j++) begin
         dqc_ff[j] <= dqc_ff[j-1];
      end
      for (int j = 0; j < DQW; j++) begin
         dqrad_ff[j] <= dqrad_src[j];
         dqrt_ff[j]  <= dqrt_in[j];
         dqrem_ff[j] <= dqrem_in[j];
      end
   end

   // ---------------------------------------------------------------- result register
   logic                  rsp_strobe_ff;
   logic                  rsp_valid_ff;
   logic [2:0][PW-1:0]    rsp_aim_ff;
   logic [DQW-1:0]        rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dqv_ff[DQW-1];
      end
   end

   // Zero every field of an item without a solution, and every field between items
   always_ff @(posedge clock) begin
      rsp_valid_ff <= dqv_ff[DQW-1] && dqc_ff[DQW-1].sol;
      rsp_aim_ff   <= (dqv_ff[DQW-1] && dqc_ff[DQW-1].sol) ? dqc_ff[DQW-1].aim : '0;
      rsp_dist_ff  <= (dqv_ff[DQW-1] && dqc_ff[DQW-1].sol) ? dqrt_ff[DQW-1] : '0;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_solution_valid = rsp_valid_ff;
   assign rsp_aim_x          = rsp_aim_ff[0];
   assign rsp_aim_y          = rsp_aim_ff[1];
   assign rsp_aim_z          = rsp_aim_ff[2];
   assign rsp_aim_distance   = rsp_dist_ff;

`ifndef SYNTHESIS
   // Every strobed result traces back to a matching item taken at the input
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result without matching item");

   // A flagged solution only appears on a strobed cycle
   a_valid_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_solution_valid |-> rsp_strobe)
      else $error("solution flag outside a result cycle");

   // A rejected item carries all-zero fields
   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_solution_valid) |->
         (rsp_aim_x == '0) && (rsp_aim_y == '0) && (rsp_aim_z == '0)
         && (rsp_aim_distance == '0))
      else $error("nonzero fields on an item without a solution");
`endif

endmodule

`default_nettype wire

>>> test/tb_intercept_lead_solver_unit.sv
// Self-checking testbench for the pipelined intercept lead solver.
`timescale 1ns / 100ps

module tb_intercept_lead_solver_unit
   import ils_pkg::*;
();

   localparam int PW      = 24;
   localparam int TFB     = 16;
   localparam int LATENCY = 122;

   typedef struct {
      logic                        present;
      logic signed [PW-1:0]        tx, ty, tz;
      logic signed [VEL_WIDTH-1:0] vx, vy, vz;
      logic signed [PW-1:0]        sx, sy, sz;
      logic [SPD_WIDTH-1:0]        speed;
   } shot_type;

   typedef struct {
      logic                 valid;
      logic signed [PW-1:0] ax, ay, az;
      logic [PW:0]          distance;
   } aim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                        req_target_present = 1'b0;
   logic signed [PW-1:0]        req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [VEL_WIDTH-1:0] req_target_vx = '0, req_target_vy = '0, req_target_vz = '0;
   logic signed [PW-1:0]        req_shooter_x = '0, req_shooter_y = '0, req_shooter_z = '0;
   logic [SPD_WIDTH-1:0]        req_projectile_speed = '0;
   logic                        rsp_strobe, rsp_solution_valid;
   logic signed [PW-1:0]        rsp_aim_x, rsp_aim_y, rsp_aim_z;
   logic [PW:0]                 rsp_aim_distance;

   shot_type pending_shots[$];
   aim_type  expected_aims[$];
   shot_type cur_shot;
   int       launched = 0;
   int       errors = 0;
   int       checked = 0;
   int       solved = 0;

   intercept_lead_solver_unit u_dut (
      .clock, .reset, .start, .busy,
      .req_target_present, .req_target_x, .req_target_y, .req_target_z,
      .req_target_vx, .req_target_vy, .req_target_vz,
      .req_shooter_x, .req_shooter_y, .req_shooter_z, .req_projectile_speed,
      .rsp_strobe, .rsp_solution_valid, .rsp_aim_x, .rsp_aim_y, .rsp_aim_z,
      .rsp_aim_distance
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] isqrt_wide(logic [127:0] n);
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [127:0] sq;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         sq = {64'd0, trial} * {64'd0, trial};
         if (sq <= n) root = trial;
      end
      return root;
   endfunction

   function automatic logic [127:0] mag_wide(longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   function automatic logic [63:0] div_limit(logic [127:0] n, logic [127:0] d,
                                             logic [63:0] lim);
      logic [127:0] q;
      q = n / d;
      return (q > {64'd0, lim}) ? lim : q[63:0];
   endfunction

   // Solve the intercept time, aim point and range for one item
   function automatic aim_type solve_lead(shot_type s);
      aim_type      res;
      longint       tp[3], vel[3], sh[3], aimv[3];
      longint       vv, rv, rr, a, r, q, num, prod, lo, hi, d;
      logic [63:0]  best, tmax, t, dist_val;
      logic [127:0] hh, ac, disc, dsum;
      logic         ok;
      res = '{valid: 1'b0, ax: '0, ay: '0, az: '0, distance: '0};
      tp  = '{longint'(s.tx), longint'(s.ty), longint'(s.tz)};
      vel = '{longint'(s.vx), longint'(s.vy), longint'(s.vz)};
      sh  = '{longint'(s.sx), longint'(s.sy), longint'(s.sz)};
      if (!s.present || s.speed == 0) return res;
      vv = 0; rv = 0; rr = 0; best = 0;
      for (int i = 0; i < 3; i++) begin
         r = tp[i] - sh[i];
         vv += vel[i] * vel[i];
         rv += r * vel[i];
         rr += r * r;
      end
      a = vv - longint'(s.speed) * longint'(s.speed);
      tmax = (64'd1 << (TIME_INT_BITS + TFB)) - 1;
      if (a == 0) begin
         // degenerate leading term: linear root only
         if (rv < 0 && rr > 0)
            best = div_limit(mag_wide(rr) << TFB, 2 * mag_wide(rv), tmax);
      end else begin
         hh = mag_wide(rv) * mag_wide(rv);
         ac = mag_wide(a) * mag_wide(rr);
         ok = 1'b1;
         disc = '0;
         if (a < 0) disc = hh + ac;
         else if (hh >= ac) disc = hh - ac;
         else ok = 1'b0;
         if (ok) begin
            q = longint'(isqrt_wide(disc));
            for (int k = 0; k < 2; k++) begin
               num = -rv + (k ? -q : q);
               if (num == 0 || ((num < 0) != (a < 0))) continue;
               t = div_limit(mag_wide(num) << TFB, mag_wide(a), tmax);
               if (t >= 1 && (best == 0 || t < best)) best = t;
            end
         end
      end
      if (best == 0) return res;
      hi = (longint'(1) << (PW - 1)) - 1;
      lo = -hi - 1;
      dsum = '0;
      for (int i = 0; i < 3; i++) begin
         prod = vel[i] * longint'(best);
         aimv[i] = tp[i] + (prod >>> TFB);
         if (aimv[i] > hi) aimv[i] = hi;
         if (aimv[i] < lo) aimv[i] = lo;
         d = aimv[i] - sh[i];
         dsum += mag_wide(d) * mag_wide(d);
      end
      dist_val = isqrt_wide(dsum);
      if (dist_val > (64'd1 << (PW + 1)) - 1) dist_val = (64'd1 << (PW + 1)) - 1;
      res.valid = 1'b1;
      res.ax = aimv[0][PW-1:0];
      res.ay = aimv[1][PW-1:0];
      res.az = aimv[2][PW-1:0];
      res.distance = dist_val[PW:0];
      return res;
   endfunction

   function automatic shot_type make_shot(logic p, longint tx, longint ty, longint tz,
                                          longint vx, longint vy, longint vz, longint sx,
                                          longint sy, longint sz, longint spd);
      shot_type s;
      s.present = p;
      s.tx = tx[PW-1:0]; s.ty = ty[PW-1:0]; s.tz = tz[PW-1:0];
      s.vx = vx[VEL_WIDTH-1:0]; s.vy = vy[VEL_WIDTH-1:0]; s.vz = vz[VEL_WIDTH-1:0];
      s.sx = sx[PW-1:0]; s.sy = sy[PW-1:0]; s.sz = sz[PW-1:0];
      s.speed = spd[SPD_WIDTH-1:0];
      return s;
   endfunction

   function automatic longint span(int bits);
      return longint'($urandom_range((1 << bits) - 1)) - (longint'(1) << (bits - 1));
   endfunction

   // Build a random item: mostly plausible engagements, some full-range noise
   function automatic shot_type random_shot();
      shot_type s;
      int       pick;
      int       vb;
      pick = $urandom_range(99);
      if (pick < 25) begin
         s.present = ($urandom_range(15) != 0);
         s.tx = PW'($urandom); s.ty = PW'($urandom); s.tz = PW'($urandom);
         s.vx = VEL_WIDTH'($urandom); s.vy = VEL_WIDTH'($urandom);
         s.vz = VEL_WIDTH'($urandom);
         s.sx = PW'($urandom); s.sy = PW'($urandom); s.sz = PW'($urandom);
         s.speed = ($urandom_range(9) == 0) ? '0 : SPD_WIDTH'($urandom);
      end else begin
         vb = $urandom_range(4, 19);
         s = make_shot($urandom_range(30) != 0, 0, 0, 0, span(vb), span(vb), span(vb),
                       span(23), span(23), span(23), 0);
         s.tx = s.sx + PW'(span($urandom_range(8, 22)));
         s.ty = s.sy + PW'(span($urandom_range(8, 22)));
         s.tz = s.sz + PW'(span($urandom_range(8, 22)));
         if (pick < 35) s.speed = SPD_WIDTH'($urandom_range(1, 255));
         else if (pick < 45) s.speed = SPD_WIDTH'($urandom_range(1, 1 << (vb - 1)));
         else s.speed = SPD_WIDTH'($urandom_range(1, (1 << SPD_WIDTH) - 1));
      end
      return s;
   endfunction

   // Drive items, predict each one at its acceptance edge
   always @(posedge clock) begin
      logic     idle;
      shot_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_aims.push_back(solve_lead(cur_shot));
            launched++;
         end
         idle = ($urandom_range(99) < 36) && !(launched > 300 && launched < 420);
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_shots.size() > 0 && !idle) begin
            nxt = pending_shots.pop_front();
            cur_shot = nxt;
            start <= 1'b1;
            req_target_present <= nxt.present;
            req_target_x <= nxt.tx; req_target_y <= nxt.ty; req_target_z <= nxt.tz;
            req_target_vx <= nxt.vx; req_target_vy <= nxt.vy; req_target_vz <= nxt.vz;
            req_shooter_x <= nxt.sx; req_shooter_y <= nxt.sy; req_shooter_z <= nxt.sz;
            req_projectile_speed <= nxt.speed;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      aim_type e;
      if (!reset && rsp_strobe) begin
         if (expected_aims.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
         end else begin
            e = expected_aims.pop_front();
            checked++;
            if (e.valid) solved++;
            if (rsp_solution_valid !== e.valid) begin
               $error("solution_valid exp %0d got %0d", e.valid, rsp_solution_valid);
               errors++;
            end
            if (rsp_aim_x !== e.ax) begin
               $error("aim_x exp %0d got %0d", e.ax, rsp_aim_x);
               errors++;
            end
            if (rsp_aim_y !== e.ay) begin
               $error("aim_y exp %0d got %0d", e.ay, rsp_aim_y);
               errors++;
            end
            if (rsp_aim_z !== e.az) begin
               $error("aim_z exp %0d got %0d", e.az, rsp_aim_z);
               errors++;
            end
            if (rsp_aim_distance !== e.distance) begin
               $error("aim_distance exp %0d got %0d", e.distance, rsp_aim_distance);
               errors++;
            end
         end
      end
   end

   // Fill the item queue, then drain and report
   initial begin
      longint pmax, pmin;
      pmax = (longint'(1) << 23) - 1;
      pmin = -(longint'(1) << 23);
      // no lock, zero speed
      pending_shots.push_back(make_shot(0, 1000, 0, 0, 10, 0, 0, 0, 0, 0, 500));
      pending_shots.push_back(make_shot(1, 1000, 0, 0, 10, 0, 0, 0, 0, 0, 0));
      // stationary target, simple and at extremes
      pending_shots.push_back(make_shot(1, 25600, 0, 0, 0, 0, 0, 0, 0, 0, 256));
      pending_shots.push_back(make_shot(1, pmax, pmax, pmax, 0, 0, 0,
                                        pmin, pmin, pmin, 524287));
      pending_shots.push_back(make_shot(1, pmin, pmax, pmin, 0, 0, 0,
                                        pmax, pmin, pmax, 1));
      // target on top of the shooter
      pending_shots.push_back(make_shot(1, 500, 500, 500, 30, 0, 0, 500, 500, 500, 100));
      // leading term zero: closing target, receding target
      pending_shots.push_back(make_shot(1, 25600, 0, 0, -256, 0, 0, 0, 0, 0, 256));
      pending_shots.push_back(make_shot(1, 25600, 0, 0, 256, 0, 0, 0, 0, 0, 256));
      pending_shots.push_back(make_shot(1, 0, 25600, 0, 0, 300, 400, 0, 0, 0, 500));
      // target outruns projectile, away and toward
      pending_shots.push_back(make_shot(1, 25600, 0, 0, 1000, 0, 0, 0, 0, 0, 100));
      pending_shots.push_back(make_shot(1, 25600, 0, 0, -1000, 0, 0, 0, 0, 0, 100));
      // negative discriminant: fast crossing target
      pending_shots.push_back(make_shot(1, 25600, 0, 0, 0, 5000, 0, 0, 0, 0, 100));
      // extreme velocities, aim saturation and time saturation
      pending_shots.push_back(make_shot(1, pmax, pmin, 0, 524287, -524288, 524287,
                                        0, 0, 0, 1));
      pending_shots.push_back(make_shot(1, pmin, pmax, pmax, -524288, 524287, -524288,
                                        pmax, pmin, pmin, 524287));
      pending_shots.push_back(make_shot(1, pmax, 0, 0, 2, 0, 0, pmin, 0, 0, 1));
      pending_shots.push_back(make_shot(1, 1, 0, 0, -1, 0, 0, 0, 0, 0, 1));
      pending_shots.push_back(make_shot(1, 10, 0, 0, 0, 0, 0, 0, 0, 0, 524287));
      for (int i = 0; i < 750; i++) pending_shots.push_back(random_shot());

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_shots.size() == 0 && !start && expected_aims.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Checked %0d results from %0d items, %0d with a valid intercept.",
               checked, launched, solved);
      if (errors == 0 && expected_aims.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
